// ===== rtl/core/combining_mark_canonical_reorder_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the combining mark reorder block
// Shared helpers; define ASSERT_OFF to compile all checks away.
// ----------------------------------------------------------------------------
`ifndef COMBINING_MARK_CANONICAL_REORDER_DEFINES_SVH
`define COMBINING_MARK_CANONICAL_REORDER_DEFINES_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define CMCR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// condition must never be true outside reset
`define CMCR_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define CMCR_ASSERT(lbl, clk, rst_n, prop, msg)
`define CMCR_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

// ===== rtl/core/cmcr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmcr_pkg
// Types and constants shared by the combining mark reorder block.
// ----------------------------------------------------------------------------
package cmcr_pkg;

    localparam int CODE_W        = 21;
    localparam int CLASS_W       = 8;
    localparam int RUN_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        S_IDLE,
        S_OVF,
        S_INSERT,
        S_PRE,
        S_END,
        S_ITEM
    } t_state;

    typedef struct packed {
        logic capture;
        logic insert;
        logic pop;
        logic load;
        logic sel_item;
        logic ovf;
        logic last;
        logic done;
    } t_dp_cmd;

    typedef struct packed {
        logic count_zero;
        logic count_one;
        logic count_full;
        logic in_starter;
        logic item_end;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/core/cmcr_ctrl.sv =====
// ----------------------------------------------------------------------------
// cmcr_ctrl
// Sequencer: accepts one item, then steps through overflow flush, insert,
// run flush and starter emit as the item requires.
// ----------------------------------------------------------------------------
module cmcr_ctrl
    import cmcr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    if (i_stat.in_starter) begin
                        n_state = i_stat.count_zero ? S_ITEM : S_PRE;
                    end else begin
                        n_state = i_stat.count_full ? S_OVF : S_INSERT;
                    end
                end
            end
            S_OVF: begin
                // drain the full run early, then place the new mark
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.pop  = 1'b1;
                    o_cmd.ovf  = 1'b1;
                    o_cmd.last = i_stat.count_one & ~i_stat.item_end;
                    if (i_stat.count_one) begin
                        n_state = S_INSERT;
                    end
                end
            end
            S_INSERT: begin
                o_cmd.insert = 1'b1;
                n_state      = i_stat.item_end ? S_END : S_IDLE;
            end
            S_PRE: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.pop  = 1'b1;
                    if (i_stat.count_one) begin
                        n_state = S_ITEM;
                    end
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.load = 1'b1;
                    o_cmd.pop  = 1'b1;
                    o_cmd.last = i_stat.count_one;
                    o_cmd.done = i_stat.count_one;
                    if (i_stat.count_one) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_ITEM: begin
                if (i_stat.out_free) begin
                    o_cmd.load     = 1'b1;
                    o_cmd.sel_item = 1'b1;
                    o_cmd.last     = 1'b1;
                    o_cmd.done     = i_stat.item_end;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/core/cmcr_dpath.sv =====
// ----------------------------------------------------------------------------
// cmcr_dpath
// Item register, sorted run buffer with parallel insert and shift-out,
// and the output register.
// ----------------------------------------------------------------------------
`include "combining_mark_canonical_reorder_defines.svh"

module cmcr_dpath
    import cmcr_pkg::*;
#(
    parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    input  logic [CODE_W-1:0]  i_code_point,
    input  logic [CLASS_W-1:0] i_combining_class,
    input  logic               i_string_end,
    input  logic               i_ready,
    output logic               o_valid,
    output logic [CODE_W-1:0]  o_out_code_point,
    output logic [CLASS_W-1:0] o_out_class,
    output logic               o_run_last,
    output logic               o_string_done,
    output logic               o_overflow
);

    localparam int CNT_W = $clog2(RUN_DEPTH + 1);

    logic [CODE_W-1:0]  r_item_cp;
    logic [CLASS_W-1:0] r_item_cc;
    logic               r_item_end;

    logic [CODE_W-1:0]  r_cp [RUN_DEPTH];
    logic [CLASS_W-1:0] r_cc [RUN_DEPTH];
    logic [CODE_W-1:0]  n_cp [RUN_DEPTH];
    logic [CLASS_W-1:0] n_cc [RUN_DEPTH];
    logic [CODE_W-1:0]  w_below_cp [RUN_DEPTH];
    logic [CLASS_W-1:0] w_below_cc [RUN_DEPTH];
    logic [CODE_W-1:0]  w_above_cp [RUN_DEPTH];
    logic [CLASS_W-1:0] w_above_cc [RUN_DEPTH];

    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic [RUN_DEPTH-1:0] w_le;
    logic [RUN_DEPTH:0]   w_le_ext;

    logic               r_out_valid;
    logic [CODE_W-1:0]  r_out_cp;
    logic [CLASS_W-1:0] r_out_cc;
    logic               r_out_last;
    logic               r_out_done;
    logic               r_out_ovf;

    // held marks of equal or lower class form a prefix: the new mark goes after it
    always_comb begin
        for (int i = 0; i < RUN_DEPTH; i++) begin
            w_le[i] = (CNT_W'(i) < r_count) && (r_cc[i] <= r_item_cc);
        end
    end

    assign w_le_ext = {w_le, 1'b1};

    for (genvar g = 0; g < RUN_DEPTH; g++) begin : g_nbr
        if (g == 0) begin : g_first
            assign w_below_cp[g] = r_item_cp;
            assign w_below_cc[g] = r_item_cc;
        end else begin : g_mid
            assign w_below_cp[g] = r_cp[g-1];
            assign w_below_cc[g] = r_cc[g-1];
        end
        if (g == RUN_DEPTH - 1) begin : g_top
            assign w_above_cp[g] = r_cp[g];
            assign w_above_cc[g] = r_cc[g];
        end else begin : g_low
            assign w_above_cp[g] = r_cp[g+1];
            assign w_above_cc[g] = r_cc[g+1];
        end
    end

    always_comb begin
        for (int i = 0; i < RUN_DEPTH; i++) begin
            n_cp[i] = r_cp[i];
            n_cc[i] = r_cc[i];
            if (i_cmd.insert) begin
                if (!w_le[i]) begin
                    n_cp[i] = w_le_ext[i] ? r_item_cp : w_below_cp[i];
                    n_cc[i] = w_le_ext[i] ? r_item_cc : w_below_cc[i];
                end
            end else if (i_cmd.pop) begin
                n_cp[i] = w_above_cp[i];
                n_cc[i] = w_above_cc[i];
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < RUN_DEPTH; i++) begin
            r_cp[i] <= n_cp[i];
            r_cc[i] <= n_cc[i];
        end
        if (i_cmd.capture) begin
            r_item_cp  <= i_code_point;
            r_item_cc  <= i_combining_class;
            r_item_end <= i_string_end;
        end
        if (i_cmd.load) begin
            r_out_cp   <= i_cmd.sel_item ? r_item_cp : r_cp[0];
            r_out_cc   <= i_cmd.sel_item ? r_item_cc : r_cc[0];
            r_out_last <= i_cmd.last;
            r_out_done <= i_cmd.done;
            r_out_ovf  <= i_cmd.ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_out_valid <= i_cmd.load | (r_out_valid & ~i_ready);
        end
    end

    assign o_stat.count_zero = (r_count == '0);
    assign o_stat.count_one  = (r_count == CNT_W'(1));
    assign o_stat.count_full = (r_count == CNT_W'(RUN_DEPTH));
    assign o_stat.in_starter = (i_combining_class == '0);
    assign o_stat.item_end   = r_item_end;
    assign o_stat.out_free   = ~r_out_valid | i_ready;

    assign o_valid          = r_out_valid;
    assign o_out_code_point = r_out_cp;
    assign o_out_class      = r_out_cc;
    assign o_run_last       = r_out_last;
    assign o_string_done    = r_out_done;
    assign o_overflow       = r_out_ovf;

    `CMCR_NEVER(a_count_range, i_clk, i_rst_n, r_count > CNT_W'(RUN_DEPTH), "run count beyond depth")
    `CMCR_NEVER(a_pop_empty, i_clk, i_rst_n, i_cmd.pop && (r_count == '0), "pop from empty run")
    `CMCR_NEVER(a_insert_full, i_clk, i_rst_n, i_cmd.insert && o_stat.count_full, "insert into full run")
    `CMCR_ASSERT(a_load_free, i_clk, i_rst_n, i_cmd.load |-> (~r_out_valid | i_ready), "output overwritten while held")
    `CMCR_ASSERT(a_ovf_last, i_clk, i_rst_n, (i_cmd.load && i_cmd.ovf && i_cmd.last) |=> (r_count == '0), "overflow run end with marks left")

endmodule

// ===== rtl/core/combining_mark_canonical_reorder.sv =====
// ----------------------------------------------------------------------------
// combining_mark_canonical_reorder
// Canonical reordering of combining marks in a code point stream.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one character with its combining
// class and an end-of-string flag. Output channel (o_valid/i_ready) carries
// emitted characters in canonical order with run_last, string_done and
// overflow flags.
// One item is worked on at a time; o_ready is high only between items.
// A mark without string end is accepted, then inserted into the run. A starter
// is accepted, the held run is shifted out and the starter is emitted; a mark
// with string end is accepted and inserted, then the whole run is shifted out.
// A mark on a full run first flushes that run early. The run buffer shifts out
// one held mark per cycle into the single output register while it is free.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; no result is dropped.
// Reset empties the run and clears the output valid; run buffer contents are
// not cleared.
// ----------------------------------------------------------------------------
module combining_mark_canonical_reorder
    import cmcr_pkg::*;
#(
    parameter int RUN_DEPTH = RUN_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [CODE_W-1:0]  i_code_point,
    input  logic [CLASS_W-1:0] i_combining_class,
    input  logic               i_string_end,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [CODE_W-1:0]  o_out_code_point,
    output logic [CLASS_W-1:0] o_out_class,
    output logic               o_run_last,
    output logic               o_string_done,
    output logic               o_overflow
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    cmcr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    cmcr_dpath #(
        .RUN_DEPTH (RUN_DEPTH)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .o_stat            (w_stat),
        .i_code_point      (i_code_point),
        .i_combining_class (i_combining_class),
        .i_string_end      (i_string_end),
        .i_ready           (i_ready),
        .o_valid           (o_valid),
        .o_out_code_point  (o_out_code_point),
        .o_out_class       (o_out_class),
        .o_run_last        (o_run_last),
        .o_string_done     (o_string_done),
        .o_overflow        (o_overflow)
    );

endmodule
